[rtl/rvrb_pkg.sv]
// Shared types, codes and constants of the variable record ring buffer.
`timescale 1ns / 1ps
package rvrb_pkg;

	localparam int BUF_BYTES_DEF = 4096;
	localparam int LEN_W = 12;
	localparam logic [15:0] END_MARK = 16'hFFFF;
	localparam logic [7:0] MARK_BYTE = 8'hFF;

	typedef enum logic [1:0] {
		CMD_PUSH_START = 2'd0,
		CMD_PUSH_BYTE = 2'd1,
		CMD_POP_BYTE = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		STS_OK = 3'd0,
		STS_ZERO = 3'd1,
		STS_NOROOM = 3'd2,
		STS_TOOBIG = 3'd3,
		STS_EMPTY = 3'd4,
		STS_NOPUSH = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_PLACE,
		ST_WM0,
		ST_WM1,
		ST_WH0,
		ST_WH1,
		ST_PBYTE,
		ST_POP0,
		ST_POP1,
		ST_DROP,
		ST_HRD0,
		ST_HRD1,
		ST_HRD2,
		ST_CLR,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] data_out;
		logic last_byte;
		logic [10:0] dropped_records;
		logic [10:0] record_count;
		logic [12:0] used_bytes;
	} result_t;

endpackage

[rtl/variable_record_ring_buffer_core.sv]
// Top level of the variable record ring buffer: stream ports, sequencer and byte store.
`timescale 1ns / 1ps
// Records are kept whole in a single-port byte memory of BUF_BYTES bytes, each as a
// two-byte little-endian length and its payload. One word is taken at a time and
// answered with exactly one result word. Every memory access takes its own state on the
// single port: a push_start may write a two-byte end marker and then writes the header,
// a push_byte writes one byte and a pop_byte reads one. The last pop_byte of a record
// drops it and, unless the queue becomes empty, reads the next header, and reads the
// header at 0 when that one is an end marker. Each record dropped to make room does the
// same. The store needs no clearing after reset, so words are accepted right after reset.
module variable_record_ring_buffer_core #(
	parameter int BUF_BYTES = rvrb_pkg::BUF_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic cfg_wr_data,
	input logic s_tvalid,
	output logic s_tready,
	input logic [23:0] s_tdata, // record_length [11:0], data_in [19:12], zero fill
	input logic [1:0] s_tuser, // command [1:0]
	output logic m_tvalid,
	input logic m_tready,
	// data_out [7:0], dropped_records [18:8], record_count [29:19], used_bytes [42:30]
	output logic [47:0] m_tdata,
	output logic [2:0] m_tuser, // status [2:0]
	output logic m_tlast
);

	localparam int AW = $clog2(BUF_BYTES);

	logic mem_we;
	logic [AW-1:0] mem_addr;
	logic [7:0] mem_wdata, mem_rdata;
	rvrb_pkg::result_t res;

	rvrb_ctrl #(.BUF_BYTES(BUF_BYTES)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_cmd(s_tuser),
		.in_len(s_tdata[11:0]),
		.in_din(s_tdata[19:12]),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res(res),
		.mem_we(mem_we),
		.mem_addr(mem_addr),
		.mem_wdata(mem_wdata),
		.mem_rdata(mem_rdata)
	);

	rvrb_mem #(.AW(AW)) u_mem (
		.clk(clk),
		.we(mem_we),
		.addr(mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	assign m_tdata = {5'b0, res.used_bytes, res.record_count, res.dropped_records,
		res.data_out};
	assign m_tuser = res.status;
	assign m_tlast = res.last_byte;

endmodule

[rtl/rvrb_mem.sv]
// Byte store: single-port synchronous memory with a registered read.
`timescale 1ns / 1ps
module rvrb_mem #(
	parameter int AW = 12
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] addr,
	input logic [7:0] wdata,
	output logic [7:0] rdata
);

	logic [7:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

[rtl/rvrb_ctrl.sv]
// Sequencer that keeps the queue pointers and drives the byte store.
`timescale 1ns / 1ps
module rvrb_ctrl #(
	parameter int BUF_BYTES = rvrb_pkg::BUF_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic cfg_wr_data,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] in_cmd,
	input logic [rvrb_pkg::LEN_W-1:0] in_len,
	input logic [7:0] in_din,
	output logic out_valid,
	input logic out_ready,
	output rvrb_pkg::result_t out_res,
	output logic mem_we,
	output logic [$clog2(BUF_BYTES)-1:0] mem_addr,
	output logic [7:0] mem_wdata,
	input logic [7:0] mem_rdata
);

	localparam int AW = $clog2(BUF_BYTES);
	localparam int PW = AW + 1;
	localparam int XW = ((PW > 14) ? PW : 14) + 1;
	localparam int LW = rvrb_pkg::LEN_W;
	localparam logic [XW-1:0] B_X = XW'(BUF_BYTES);

	rvrb_pkg::state_t state_q, state_d;
	logic [LW-1:0] len_q, len_d;
	logic [7:0] din_q, din_d;
	logic [PW-1:0] head_q, head_d, newest_q, newest_d, wpos_q, wpos_d, mark_q, mark_d;
	logic [LW-1:0] head_len_q, head_len_d, newest_len_q, newest_len_d, wlen_q, wlen_d;
	logic [LW-1:0] push_left_q, push_left_d, pop_left_q, pop_left_d;
	logic push_open_q, push_open_d;
	logic [PW-1:0] count_q, count_d, biu_q, biu_d, dropped_q, dropped_d;
	logic ovw_q;
	logic [7:0] lo_q, lo_d;
	logic second_q, second_d, push_mode_q, push_mode_d;
	rvrb_pkg::status_t status_q, status_d;
	logic [7:0] dout_q, dout_d;
	logic last_q, last_d, mvalid_q, mvalid_d;

	logic [XW-1:0] head_x, newest_x, biu_x, cnt_x, drop_x, sto_x, pos_x, tail_x;
	logic [XW-1:0] dsto_x, hn_x, biu_new_x, pb_addr_x, pop_addr_x;
	logic [LW-1:0] pl;
	logic [15:0] hdr_v;
	logic fits, do_mark;
	logic [PW-1:0] at_pos;
	rvrb_pkg::state_t ret_state;

	always_comb begin
		head_x = XW'(head_q);
		newest_x = XW'(newest_q);
		biu_x = XW'(biu_q);
		cnt_x = XW'(count_q);
		drop_x = XW'(dropped_q);
		sto_x = XW'(len_q) + XW'(2);
		pos_x = newest_x + XW'(newest_len_q) + XW'(2);
		tail_x = (pos_x < B_X) ? (B_X - pos_x) : '0;
		fits = 1'b0;
		do_mark = 1'b0;
		at_pos = '0;
		if ((B_X - biu_x) >= sto_x) begin
			if (count_q == '0) begin
				fits = 1'b1;
			end else if (newest_q >= head_q) begin
				if (tail_x >= sto_x) begin
					fits = 1'b1;
					at_pos = PW'(pos_x);
				end else if (head_x >= sto_x) begin
					fits = 1'b1;
					do_mark = (tail_x >= XW'(2));
				end
			end else if (!(pos_x > head_x) && ((head_x - pos_x) >= sto_x)) begin
				fits = 1'b1;
				at_pos = PW'(pos_x);
			end
		end
		dsto_x = XW'(head_len_q) + XW'(2);
		hn_x = head_x + dsto_x;
		biu_new_x = (biu_x >= dsto_x) ? (biu_x - dsto_x) : '0;
		pb_addr_x = XW'(wpos_q) + XW'(2) + XW'(wlen_q - push_left_q);
		pl = ((pop_left_q == '0) || (pop_left_q > head_len_q)) ? head_len_q : pop_left_q;
		pop_addr_x = head_x + XW'(2) + XW'(head_len_q - pl);
		hdr_v = {mem_rdata, lo_q};
		ret_state = push_mode_q ? rvrb_pkg::ST_PLACE : rvrb_pkg::ST_FIN;
	end

	always_comb begin
		state_d = state_q;
		len_d = len_q;
		din_d = din_q;
		head_d = head_q;
		newest_d = newest_q;
		wpos_d = wpos_q;
		mark_d = mark_q;
		head_len_d = head_len_q;
		newest_len_d = newest_len_q;
		wlen_d = wlen_q;
		push_left_d = push_left_q;
		pop_left_d = pop_left_q;
		push_open_d = push_open_q;
		count_d = count_q;
		biu_d = biu_q;
		dropped_d = dropped_q;
		lo_d = lo_q;
		second_d = second_q;
		push_mode_d = push_mode_q;
		status_d = status_q;
		dout_d = dout_q;
		last_d = last_q;
		mvalid_d = mvalid_q & ~out_ready;
		mem_we = 1'b0;
		mem_addr = '0;
		mem_wdata = '0;
		in_ready = 1'b0;
		case (state_q)
			rvrb_pkg::ST_IDLE: begin
				in_ready = ~mvalid_q | out_ready;
				if (in_valid && in_ready) begin
					len_d = in_len;
					din_d = in_din;
					status_d = rvrb_pkg::STS_OK;
					dout_d = '0;
					last_d = 1'b0;
					dropped_d = '0;
					case (rvrb_pkg::cmd_t'(in_cmd))
						rvrb_pkg::CMD_PUSH_START: state_d = rvrb_pkg::ST_START;
						rvrb_pkg::CMD_PUSH_BYTE: state_d = rvrb_pkg::ST_PBYTE;
						rvrb_pkg::CMD_POP_BYTE: state_d = rvrb_pkg::ST_POP0;
						default: state_d = rvrb_pkg::ST_CLR;
					endcase
				end
			end
			rvrb_pkg::ST_START: begin
				push_open_d = 1'b0;
				push_left_d = '0;
				if (len_q == '0) begin
					status_d = rvrb_pkg::STS_ZERO;
					state_d = rvrb_pkg::ST_FIN;
				end else if (sto_x > B_X) begin
					status_d = rvrb_pkg::STS_TOOBIG;
					state_d = rvrb_pkg::ST_FIN;
				end else begin
					state_d = rvrb_pkg::ST_PLACE;
				end
			end
			rvrb_pkg::ST_PLACE: begin
				if (!fits) begin
					if (ovw_q && (count_q != '0)) begin
						push_mode_d = 1'b1;
						state_d = rvrb_pkg::ST_DROP;
					end else begin
						status_d = rvrb_pkg::STS_NOROOM;
						state_d = rvrb_pkg::ST_FIN;
					end
				end else begin
					wpos_d = at_pos;
					wlen_d = len_q;
					push_left_d = len_q;
					push_open_d = 1'b1;
					mark_d = PW'(pos_x);
					state_d = do_mark ? rvrb_pkg::ST_WM0 : rvrb_pkg::ST_WH0;
				end
			end
			rvrb_pkg::ST_WM0: begin
				mem_we = 1'b1;
				mem_addr = mark_q[AW-1:0];
				mem_wdata = rvrb_pkg::MARK_BYTE;
				state_d = rvrb_pkg::ST_WM1;
			end
			rvrb_pkg::ST_WM1: begin
				mem_we = 1'b1;
				mem_addr = AW'(mark_q + PW'(1));
				mem_wdata = rvrb_pkg::MARK_BYTE;
				state_d = rvrb_pkg::ST_WH0;
			end
			rvrb_pkg::ST_WH0: begin
				mem_we = 1'b1;
				mem_addr = wpos_q[AW-1:0];
				mem_wdata = len_q[7:0];
				state_d = rvrb_pkg::ST_WH1;
			end
			rvrb_pkg::ST_WH1: begin
				mem_we = 1'b1;
				mem_addr = AW'(wpos_q + PW'(1));
				mem_wdata = 8'(len_q[LW-1:8]);
				state_d = rvrb_pkg::ST_FIN;
			end
			rvrb_pkg::ST_PBYTE: begin
				state_d = rvrb_pkg::ST_FIN;
				if (!push_open_q || (push_left_q == '0)) begin
					status_d = rvrb_pkg::STS_NOPUSH;
				end else begin
					mem_we = 1'b1;
					mem_addr = pb_addr_x[AW-1:0];
					mem_wdata = din_q;
					push_left_d = push_left_q - LW'(1);
					if (push_left_q == LW'(1)) begin
						push_open_d = 1'b0;
						if (count_q == '0) begin
							head_d = wpos_q;
							head_len_d = wlen_q;
						end
						newest_d = wpos_q;
						newest_len_d = wlen_q;
						count_d = count_q + PW'(1);
						biu_d = PW'(biu_x + XW'(wlen_q) + XW'(2));
					end
				end
			end
			rvrb_pkg::ST_POP0: begin
				if (count_q == '0) begin
					status_d = rvrb_pkg::STS_EMPTY;
					state_d = rvrb_pkg::ST_FIN;
				end else begin
					mem_addr = pop_addr_x[AW-1:0];
					pop_left_d = (pl != '0) ? (pl - LW'(1)) : '0;
					state_d = rvrb_pkg::ST_POP1;
				end
			end
			rvrb_pkg::ST_POP1: begin
				dout_d = mem_rdata;
				if (pop_left_q == '0) begin
					last_d = 1'b1;
					push_mode_d = 1'b0;
					state_d = rvrb_pkg::ST_DROP;
				end else begin
					state_d = rvrb_pkg::ST_FIN;
				end
			end
			rvrb_pkg::ST_DROP: begin
				if (push_mode_q) begin
					dropped_d = PW'(drop_x + XW'(1));
				end
				biu_d = PW'(biu_new_x);
				count_d = (count_q != '0) ? (count_q - PW'(1)) : '0;
				pop_left_d = '0;
				if (cnt_x <= XW'(1)) begin
					head_d = '0;
					newest_d = '0;
					state_d = ret_state;
				end else if ((hn_x + XW'(2)) > B_X) begin
					head_d = '0;
					second_d = 1'b1;
					state_d = rvrb_pkg::ST_HRD0;
				end else begin
					head_d = PW'(hn_x);
					second_d = 1'b0;
					state_d = rvrb_pkg::ST_HRD0;
				end
			end
			rvrb_pkg::ST_HRD0: begin
				mem_addr = head_q[AW-1:0];
				state_d = rvrb_pkg::ST_HRD1;
			end
			rvrb_pkg::ST_HRD1: begin
				mem_addr = AW'(head_q + PW'(1));
				lo_d = mem_rdata;
				state_d = rvrb_pkg::ST_HRD2;
			end
			rvrb_pkg::ST_HRD2: begin
				if (!second_q && (hdr_v == rvrb_pkg::END_MARK)) begin
					head_d = '0;
					second_d = 1'b1;
					state_d = rvrb_pkg::ST_HRD0;
				end else begin
					head_len_d = hdr_v[LW-1:0];
					state_d = ret_state;
				end
			end
			rvrb_pkg::ST_CLR: begin
				head_d = '0;
				newest_d = '0;
				wpos_d = '0;
				push_left_d = '0;
				push_open_d = 1'b0;
				pop_left_d = '0;
				count_d = '0;
				biu_d = '0;
				state_d = rvrb_pkg::ST_FIN;
			end
			rvrb_pkg::ST_FIN: begin
				mvalid_d = 1'b1;
				state_d = rvrb_pkg::ST_IDLE;
			end
			default: begin
				state_d = rvrb_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rvrb_pkg::ST_IDLE;
			head_q <= '0;
			newest_q <= '0;
			wpos_q <= '0;
			push_left_q <= '0;
			push_open_q <= 1'b0;
			pop_left_q <= '0;
			count_q <= '0;
			biu_q <= '0;
			mvalid_q <= 1'b0;
			ovw_q <= 1'b1;
		end else begin
			state_q <= state_d;
			head_q <= head_d;
			newest_q <= newest_d;
			wpos_q <= wpos_d;
			push_left_q <= push_left_d;
			push_open_q <= push_open_d;
			pop_left_q <= pop_left_d;
			count_q <= count_d;
			biu_q <= biu_d;
			mvalid_q <= mvalid_d;
			if (cfg_wr_en) begin
				ovw_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		len_q <= len_d;
		din_q <= din_d;
		mark_q <= mark_d;
		head_len_q <= head_len_d;
		newest_len_q <= newest_len_d;
		wlen_q <= wlen_d;
		dropped_q <= dropped_d;
		lo_q <= lo_d;
		second_q <= second_d;
		push_mode_q <= push_mode_d;
		status_q <= status_d;
		dout_q <= dout_d;
		last_q <= last_d;
	end

	assign out_valid = mvalid_q;
	assign out_res.status = status_q;
	assign out_res.data_out = dout_q;
	assign out_res.last_byte = last_q;
	assign out_res.dropped_records = drop_x[10:0];
	assign out_res.record_count = cnt_x[10:0];
	assign out_res.used_bytes = biu_x[12:0];

`ifndef ASSERT_OFF
	a_biu_bound: assert property (@(posedge clk) disable iff (!arst_n)
		biu_x <= B_X) else $error("Stored byte count exceeds the buffer size.");
	a_empty_no_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (biu_q == '0)) else $error("Empty queue holds bytes.");
	a_open_has_left: assert property (@(posedge clk) disable iff (!arst_n)
		push_open_q |-> (push_left_q != '0)) else $error("Open push with no bytes left.");
	a_accept_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !mvalid_q) else $error("Result pending after accept.");
`endif

endmodule

[tb/sv/variable_record_ring_buffer_core_checker.sv]
// Checker for the variable record ring buffer: predicts every result word and compares it.
`timescale 1ns / 1ps
module variable_record_ring_buffer_core_checker
	import rvrb_pkg::*;
#(
	parameter int BUF_BYTES = BUF_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic cfg_wr_data,
	input logic s_tvalid,
	input logic s_tready,
	input logic [23:0] s_tdata, // record_length [11:0], data_in [19:12], zero fill
	input logic [1:0] s_tuser, // command [1:0]
	input logic m_tvalid,
	input logic m_tready,
	// data_out [7:0], dropped_records [18:8], record_count [29:19], used_bytes [42:30]
	input logic [47:0] m_tdata,
	input logic [2:0] m_tuser, // status [2:0]
	input logic m_tlast,
	output int errors,
	output int pending
);

	logic [7:0] shadow_mem [BUF_BYTES];
	int unsigned head_at, newest_at, open_at, push_left, pop_left, rec_count, used;
	bit push_active, overwrite;
	result_t expected_words [$];

	function automatic int unsigned peek(int unsigned a);
		return a < BUF_BYTES ? shadow_mem[a] : 0;
	endfunction

	function automatic void poke(int unsigned a, int unsigned v);
		if (a < BUF_BYTES) shadow_mem[a] = v[7:0];
	endfunction

	function automatic int unsigned header_at(int unsigned a);
		return peek(a) | (peek(a + 1) << 8);
	endfunction

	// 0 no fit, 1 fits at spot, 2 fits at 0 with end marker at mark, 3 fits at 0.
	function automatic int find_room(int unsigned need, output int unsigned spot,
			output int unsigned mark);
		int unsigned pos, tail;
		spot = 0;
		mark = 0;
		if (used > BUF_BYTES || BUF_BYTES - used < need) return 0;
		if (rec_count == 0) return 1;
		pos = newest_at + header_at(newest_at) + 2;
		if (newest_at >= head_at) begin
			tail = pos < BUF_BYTES ? BUF_BYTES - pos : 0;
			if (tail >= need) begin
				spot = pos;
				return 1;
			end
			if (head_at < need) return 0;
			if (tail >= 2) begin
				mark = pos;
				return 2;
			end
			return 3;
		end
		if (pos > head_at || head_at - pos < need) return 0;
		spot = pos;
		return 1;
	endfunction

	function automatic void drop_oldest();
		int unsigned sz;
		sz = header_at(head_at) + 2;
		head_at += sz;
		used = used >= sz ? used - sz : 0;
		if (rec_count > 0) rec_count--;
		pop_left = 0;
		if (rec_count == 0) begin
			head_at = 0;
			newest_at = 0;
		end else if (head_at + 2 > BUF_BYTES || header_at(head_at) == END_MARK) begin
			head_at = 0;
		end
	endfunction

	function automatic result_t apply_word(logic [1:0] cmd, int unsigned len, logic [7:0] din);
		result_t r;
		int unsigned spot, mark, plen, done, dropped;
		int how;
		r = '0;
		r.status = STS_OK;
		dropped = 0;
		case (cmd)
			CMD_PUSH_START: begin
				push_active = 0;
				push_left = 0;
				if (len == 0) begin
					r.status = STS_ZERO;
				end else if (len + 2 > BUF_BYTES) begin
					r.status = STS_TOOBIG;
				end else begin
					how = find_room(len + 2, spot, mark);
					while (how == 0 && overwrite && rec_count > 0) begin
						drop_oldest();
						dropped++;
						how = find_room(len + 2, spot, mark);
					end
					if (how == 0) begin
						r.status = STS_NOROOM;
					end else begin
						if (how == 2) begin
							poke(mark, MARK_BYTE);
							poke(mark + 1, MARK_BYTE);
						end
						poke(spot, len & 8'hFF);
						poke(spot + 1, len >> 8);
						open_at = spot;
						push_left = len;
						push_active = 1;
					end
				end
			end
			CMD_PUSH_BYTE: begin
				if (!push_active || push_left == 0) begin
					r.status = STS_NOPUSH;
				end else begin
					plen = header_at(open_at);
					done = plen >= push_left ? plen - push_left : 0;
					poke(open_at + 2 + done, din);
					push_left--;
					if (push_left == 0) begin
						push_active = 0;
						if (rec_count == 0) head_at = open_at;
						newest_at = open_at;
						rec_count++;
						used += plen + 2;
					end
				end
			end
			CMD_POP_BYTE: begin
				if (rec_count == 0) begin
					r.status = STS_EMPTY;
				end else begin
					plen = header_at(head_at);
					if (pop_left == 0 || pop_left > plen) pop_left = plen;
					done = plen - pop_left;
					r.data_out = 8'(peek(head_at + 2 + done));
					if (pop_left > 0) pop_left--;
					if (pop_left == 0) begin
						r.last_byte = 1'b1;
						drop_oldest();
					end
				end
			end
			default: begin
				head_at = 0;
				newest_at = 0;
				open_at = 0;
				push_left = 0;
				push_active = 0;
				pop_left = 0;
				rec_count = 0;
				used = 0;
			end
		endcase
		r.dropped_records = 11'(dropped);
		r.record_count = 11'(rec_count);
		r.used_bytes = 13'(used);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			foreach (shadow_mem[i]) shadow_mem[i] = '0;
			head_at = 0;
			newest_at = 0;
			open_at = 0;
			push_left = 0;
			pop_left = 0;
			rec_count = 0;
			used = 0;
			push_active = 0;
			overwrite = 1;
			expected_words.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_wr_en) overwrite = cfg_wr_data;
			if (m_tvalid && m_tready) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected result word %h status %0d", $time, m_tdata, m_tuser);
					errors++;
				end else begin
					want = expected_words.pop_front();
					if (m_tuser !== want.status || m_tdata[7:0] !== want.data_out ||
							m_tlast !== want.last_byte || m_tdata[18:8] !== want.dropped_records ||
							m_tdata[29:19] !== want.record_count ||
							m_tdata[42:30] !== want.used_bytes || m_tdata[47:43] !== 5'd0) begin
						$display("%0t: mismatch expected sts %0d dout %h last %b drop %0d cnt %0d used %0d",
							$time, want.status, want.data_out, want.last_byte,
							want.dropped_records, want.record_count, want.used_bytes);
						$display("%0t:          actual sts %0d dout %h last %b drop %0d cnt %0d used %0d",
							$time, m_tuser, m_tdata[7:0], m_tlast, m_tdata[18:8],
							m_tdata[29:19], m_tdata[42:30]);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_words.push_back(apply_word(s_tuser, s_tdata[11:0], s_tdata[19:12]));
			pending = expected_words.size();
		end
	end

endmodule

[tb/sv/variable_record_ring_buffer_core_test.sv]
// Top of the variable record ring buffer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module variable_record_ring_buffer_core_test;
	import rvrb_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_wr_en = 0;
	logic cfg_wr_data = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [23:0] s_tdata = '0;
	logic [1:0] s_tuser = CMD_CLEAR;
	logic m_tvalid;
	logic m_tready = 0;
	logic [47:0] m_tdata;
	logic [2:0] m_tuser;
	logic m_tlast;
	int errors, pending;
	int sent = 0;
	bit steady = 0;

	always #5 clk = ~clk;

	variable_record_ring_buffer_core u_dut (.*);

	variable_record_ring_buffer_core_checker u_chk (.*);

	always @(posedge clk) m_tready <= steady || $urandom_range(99) >= 23;

	task automatic send_word(cmd_t cmd, int unsigned len, logic [7:0] din);
		if (!steady && $urandom_range(99) < 23) begin
			s_tvalid <= 0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= cmd;
		s_tdata <= {4'd0, din, len[11:0]};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
	endtask

	task automatic push_record(int unsigned len, int unsigned give);
		send_word(CMD_PUSH_START, len, $urandom);
		for (int unsigned i = 0; i < give; i++) send_word(CMD_PUSH_BYTE, $urandom, $urandom);
	endtask

	task automatic set_overwrite(bit v);
		s_tvalid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		cfg_wr_en <= 1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 0;
		@(posedge clk);
	endtask

	task automatic random_word();
		int unsigned r, len;
		r = $urandom_range(99);
		if (r < 45) begin
			len = $urandom_range(99) < 8 ? $urandom_range(200, 60) : $urandom_range(24, 1);
			push_record(len, $urandom_range(9) == 0 ? $urandom_range(len) : len);
		end else if (r < 75) begin
			repeat ($urandom_range(8, 1)) send_word(CMD_POP_BYTE, $urandom, $urandom);
		end else if (r < 80) begin
			send_word(CMD_PUSH_BYTE, $urandom, $urandom);
		end else if (r < 83) begin
			send_word(CMD_PUSH_START, $urandom_range(1) ? 0 : 4095, $urandom);
		end else if (r < 85) begin
			send_word(CMD_CLEAR, $urandom, $urandom);
		end else begin
			send_word(CMD_POP_BYTE, $urandom, $urandom);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		set_overwrite(1);
		send_word(CMD_PUSH_BYTE, 0, 8'hFF);
		send_word(CMD_POP_BYTE, 12'hFFF, 0);
		send_word(CMD_PUSH_START, 0, 0);
		send_word(CMD_PUSH_START, 4095, 0);
		push_record(3, 3);
		push_record(4, 4);
		send_word(CMD_PUSH_START, 4094, 0);
		send_word(CMD_PUSH_BYTE, 0, 8'h5A);
		send_word(CMD_POP_BYTE, 0, 0);
		push_record(3, 3);
		send_word(CMD_POP_BYTE, 0, 0);
		push_record(3, 3);
		send_word(CMD_CLEAR, 0, 0);
		send_word(CMD_POP_BYTE, 0, 0);
		push_record(5, 2);
		push_record(2, 2);
		send_word(CMD_PUSH_BYTE, 0, 0);
		repeat (3) send_word(CMD_POP_BYTE, 0, 0);
		set_overwrite(0);
		push_record(6, 6);
		send_word(CMD_PUSH_START, 4094, 0);
		send_word(CMD_POP_BYTE, 0, 0);
		send_word(CMD_CLEAR, 0, 0);
		sent = 0;
		set_overwrite(1);
		while (sent < 220) random_word();
		steady = 1;
		while (sent < 380) random_word();
		steady = 0;
		set_overwrite(0);
		while (sent < 520) random_word();
		set_overwrite(1);
		while (sent < 650) random_word();
		s_tvalid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("variable_record_ring_buffer_core_test: clean");
		else
			$display("variable_record_ring_buffer_core_test: errors");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("variable_record_ring_buffer_core_test: errors");
		$finish;
	end

endmodule
